### rtl/core/gaeas_pkg.sv
// ---------------------------------------------------------------------------
// gaeas_pkg
// Shared constants and types for the advantage estimation stream core.
// ---------------------------------------------------------------------------
package gaeas_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH         = 32;
   localparam int DATA_WIDTH          = 2 * FIELD_WIDTH;
   localparam int USER_WIDTH          = 2;
   localparam int FRAC_BITS           = 16;
   localparam int FACTOR_WIDTH        = 17;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int MODE_WIDTH          = 2;

   localparam logic [FACTOR_WIDTH-1:0] ONE_Q16      = 17'd65536;
   localparam logic [FACTOR_WIDTH-1:0] GAMMA_RESET  = 17'd64880;
   localparam logic [FACTOR_WIDTH-1:0] LAMBDA_RESET = 17'd62259;

   // estimate modes
   localparam logic [MODE_WIDTH-1:0] MODE_TRAJECTORY = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_ESTIMATOR  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SUM        = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAMMA  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAMBDA = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE   = 2'd2;

   localparam logic signed [FIELD_WIDTH-1:0] FIELD_MAX = 32'sh7fff_ffff;
   localparam logic signed [FIELD_WIDTH-1:0] FIELD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic sum_mode;   // plain discounted sum
      logic carry_en;   // carry term taken into the accumulator
      logic restart;    // first item of a trajectory
   } step_ctl_type;

endpackage

### rtl/core/gaeas_scale.sv
// ---------------------------------------------------------------------------
// gaeas_scale
// Signed value times unsigned Q1.16 factor, rounded half away from zero.
// ---------------------------------------------------------------------------
module gaeas_scale #(
   parameter int VALUE_WIDTH = gaeas_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic signed [VALUE_WIDTH-1:0]          value,
   input  logic [gaeas_pkg::FACTOR_WIDTH-1:0]     factor,
   output logic signed [VALUE_WIDTH-1:0]          product
);

   localparam int PW = VALUE_WIDTH + gaeas_pkg::FACTOR_WIDTH;

   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic [PW-1:0]          prod;
   logic [PW-1:0]          rounded;
   logic [VALUE_WIDTH-1:0] res_mag;

   // factor is at most one, so the magnitude never grows past the input's
   assign neg     = value[VALUE_WIDTH-1];
   assign mag     = neg ? (VALUE_WIDTH'(0) - value) : value;
   assign prod    = PW'(mag) * PW'(factor);
   assign rounded = prod + PW'(1 << (gaeas_pkg::FRAC_BITS - 1));
   assign res_mag = rounded[gaeas_pkg::FRAC_BITS +: VALUE_WIDTH];
   assign product = neg ? (VALUE_WIDTH'(0) - res_mag) : res_mag;

endmodule

### rtl/core/gaeas_sat_add.sv
// ---------------------------------------------------------------------------
// gaeas_sat_add
// Saturating signed add or subtract at the internal value width.
// ---------------------------------------------------------------------------
module gaeas_sat_add #(
   parameter int VALUE_WIDTH = gaeas_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic signed [VALUE_WIDTH-1:0] a,
   input  logic signed [VALUE_WIDTH-1:0] b,
   input  logic                          sub,
   output logic signed [VALUE_WIDTH-1:0] y
);

   logic signed [VALUE_WIDTH:0] ax;
   logic signed [VALUE_WIDTH:0] bx;
   logic signed [VALUE_WIDTH:0] s;

   assign ax = {a[VALUE_WIDTH-1], a};
   assign bx = {b[VALUE_WIDTH-1], b};
   assign s  = sub ? (ax - bx) : (ax + bx);

   always_comb begin
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         y = s[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                            : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else begin
         y = s[VALUE_WIDTH-1:0];
      end
   end

endmodule

### rtl/core/gaeas_delta.sv
// ---------------------------------------------------------------------------
// gaeas_delta
// Temporal difference stage: bootstraps from the later step and registers
// the delta together with the carry controls for the accumulator.
// ---------------------------------------------------------------------------
module gaeas_delta #(
   parameter int VALUE_WIDTH = gaeas_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic signed [VALUE_WIDTH-1:0]       reward,
   input  logic signed [VALUE_WIDTH-1:0]       value,
   input  logic                                not_done,
   input  logic                                final_step,
   input  logic [gaeas_pkg::MODE_WIDTH-1:0]    mode,
   input  logic [gaeas_pkg::FACTOR_WIDTH-1:0]  gamma_lim,
   output logic signed [VALUE_WIDTH-1:0]       delta_ff,
   output logic signed [VALUE_WIDTH-1:0]       value_ff,
   output gaeas_pkg::step_ctl_type             ctl_ff
);

   logic signed [VALUE_WIDTH-1:0] later_value_ff;
   logic                          later_not_done_ff;

   logic signed [VALUE_WIDTH-1:0] lv;
   logic                          lnd;
   logic signed [VALUE_WIDTH-1:0] boot_p;
   logic signed [VALUE_WIDTH-1:0] boot;
   logic signed [VALUE_WIDTH-1:0] rb;
   logic signed [VALUE_WIDTH-1:0] td;
   logic                          boot_en;
   gaeas_pkg::step_ctl_type       ctl_in;
   logic signed [VALUE_WIDTH-1:0] delta_in;

   // a new trajectory has no later step to bootstrap from
   assign lv  = final_step ? '0 : later_value_ff;
   assign lnd = final_step ? 1'b0 : later_not_done_ff;

   gaeas_scale #(.VALUE_WIDTH(VALUE_WIDTH)) u_boot (
      .value   (lv),
      .factor  (gamma_lim),
      .product (boot_p)
   );

   always_comb begin
      ctl_in.restart = final_step;
      unique case (mode)
         gaeas_pkg::MODE_SUM: begin
            boot_en         = 1'b0;
            ctl_in.sum_mode = 1'b1;
            ctl_in.carry_en = 1'b1;
         end
         gaeas_pkg::MODE_ESTIMATOR: begin
            boot_en         = not_done;
            ctl_in.sum_mode = 1'b0;
            ctl_in.carry_en = 1'b1;
         end
         default: begin
            boot_en         = lnd;
            ctl_in.sum_mode = 1'b0;
            ctl_in.carry_en = not_done;
         end
      endcase
   end

   assign boot = boot_en ? boot_p : '0;

   gaeas_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_add_boot (
      .a   (reward),
      .b   (boot),
      .sub (1'b0),
      .y   (rb)
   );

   gaeas_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_sub_value (
      .a   (rb),
      .b   (value),
      .sub (1'b1),
      .y   (td)
   );

   // the discounted sum feeds the reward straight into the accumulator
   assign delta_in = ctl_in.sum_mode ? reward : td;

   always_ff @(posedge clock) begin
      if (reset) begin
         later_value_ff    <= '0;
         later_not_done_ff <= 1'b0;
      end else if (load) begin
         later_value_ff    <= value;
         later_not_done_ff <= not_done;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         delta_ff <= delta_in;
         value_ff <= value;
         ctl_ff   <= ctl_in;
      end
   end

endmodule

### rtl/core/gaeas_accum.sv
// ---------------------------------------------------------------------------
// gaeas_accum
// Running advantage: scales the held accumulator and adds the new delta.
// ---------------------------------------------------------------------------
module gaeas_accum #(
   parameter int VALUE_WIDTH = gaeas_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic signed [VALUE_WIDTH-1:0]       delta,
   input  logic signed [VALUE_WIDTH-1:0]       value,
   input  gaeas_pkg::step_ctl_type             ctl,
   input  logic [gaeas_pkg::FACTOR_WIDTH-1:0]  gamma_lim,
   input  logic [gaeas_pkg::FACTOR_WIDTH-1:0]  gamma_lambda,
   output logic signed [VALUE_WIDTH-1:0]       acc_ff,
   output logic signed [VALUE_WIDTH-1:0]       value_ff,
   output logic                                sum_mode_ff
);

   logic signed [VALUE_WIDTH-1:0]      prev;
   logic [gaeas_pkg::FACTOR_WIDTH-1:0] factor;
   logic signed [VALUE_WIDTH-1:0]      carry_p;
   logic signed [VALUE_WIDTH-1:0]      carry;
   logic signed [VALUE_WIDTH-1:0]      acc_in;

   // acc_ff doubles as the running advantage across items
   assign prev   = ctl.restart ? '0 : acc_ff;
   assign factor = ctl.sum_mode ? gamma_lim : gamma_lambda;

   gaeas_scale #(.VALUE_WIDTH(VALUE_WIDTH)) u_carry (
      .value   (prev),
      .factor  (factor),
      .product (carry_p)
   );

   assign carry = ctl.carry_en ? carry_p : '0;

   gaeas_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_acc (
      .a   (delta),
      .b   (carry),
      .sub (1'b0),
      .y   (acc_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (load) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff    <= value;
         sum_mode_ff <= ctl.sum_mode;
      end
   end

endmodule

### rtl/core/gaeas_out.sv
// ---------------------------------------------------------------------------
// gaeas_out
// Result register: forms advantage and return and clamps them to 32 bits.
// ---------------------------------------------------------------------------
module gaeas_out #(
   parameter int VALUE_WIDTH = gaeas_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic signed [VALUE_WIDTH-1:0]          acc,
   input  logic signed [VALUE_WIDTH-1:0]          value,
   input  logic                                   sum_mode,
   output logic [gaeas_pkg::FIELD_WIDTH-1:0]      advantage_ff,
   output logic [gaeas_pkg::FIELD_WIDTH-1:0]      return_ff
);

   localparam int EW = (VALUE_WIDTH > gaeas_pkg::FIELD_WIDTH) ? VALUE_WIDTH
                                                              : gaeas_pkg::FIELD_WIDTH;
   localparam logic signed [EW-1:0] OUT_MAX = EW'(gaeas_pkg::FIELD_MAX);
   localparam logic signed [EW-1:0] OUT_MIN = EW'(gaeas_pkg::FIELD_MIN);

   function automatic logic [gaeas_pkg::FIELD_WIDTH-1:0] clamp_field(
      input logic signed [VALUE_WIDTH-1:0] a
   );
      logic signed [EW-1:0] x;
      x = EW'(a);
      if (x > OUT_MAX) begin
         clamp_field = gaeas_pkg::FIELD_MAX;
      end else if (x < OUT_MIN) begin
         clamp_field = gaeas_pkg::FIELD_MIN;
      end else begin
         clamp_field = x[gaeas_pkg::FIELD_WIDTH-1:0];
      end
   endfunction

   logic signed [VALUE_WIDTH-1:0] diff;
   logic signed [VALUE_WIDTH-1:0] total;
   logic signed [VALUE_WIDTH-1:0] adv_w;
   logic signed [VALUE_WIDTH-1:0] ret_w;

   gaeas_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_diff (
      .a   (acc),
      .b   (value),
      .sub (1'b1),
      .y   (diff)
   );

   gaeas_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_total (
      .a   (acc),
      .b   (value),
      .sub (1'b0),
      .y   (total)
   );

   // discounted sum is the return; the advantage is taken against the value
   assign adv_w = sum_mode ? diff : acc;
   assign ret_w = sum_mode ? acc : total;

   always_ff @(posedge clock) begin
      if (load) begin
         advantage_ff <= clamp_field(adv_w);
         return_ff    <= clamp_field(ret_w);
      end
   end

endmodule

### rtl/core/gae_advantage_stream_core.sv
// ---------------------------------------------------------------------------
// gae_advantage_stream_core
// Generalised advantage estimation over a trajectory streamed in reverse.
//
// Channel  Dir  Handshake         Contents
// req      in   tvalid/tready     tdata: reward_in, value_in; tuser: not_done, final_step
// rsp      out  tvalid/tready     tdata: advantage_out, return_out
// csr      in   csr_wen           csr_index selects register, csr_wdata written
//
// One item per cycle sustained while results are taken; an item that is accepted
// passes through the input register, delta stage, accumulator stage and result register.
// The accumulator loop, one scaling multiply and one saturating add, sets the
// cycle. Each stage refills as soon as the one after it moves, so a stalled
// result holds only the items behind it. Reset clears the valid bits and the
// running state and restores the register defaults.
// ---------------------------------------------------------------------------
module gae_advantage_stream_core #(
   parameter int VALUE_WIDTH = gaeas_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // reward_in [31:0], value_in [63:32]
   input  logic [gaeas_pkg::DATA_WIDTH-1:0]         req_tdata,
   // not_done [0], final_step [1]
   input  logic [gaeas_pkg::USER_WIDTH-1:0]         req_tuser,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // advantage_out [31:0], return_out [63:32]
   output logic [gaeas_pkg::DATA_WIDTH-1:0]         rsp_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic                                     csr_wen,
   input  logic [gaeas_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [gaeas_pkg::FACTOR_WIDTH-1:0]       csr_wdata
);

   localparam int FW = gaeas_pkg::FIELD_WIDTH;
   localparam int KW = gaeas_pkg::FACTOR_WIDTH;
   localparam int EW = (VALUE_WIDTH > FW) ? VALUE_WIDTH : FW;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [EW-1:0] VAL_MAX_E = EW'(VAL_MAX);
   localparam logic signed [EW-1:0] VAL_MIN_E = EW'(VAL_MIN);

   function automatic logic signed [VALUE_WIDTH-1:0] clamp_value(
      input logic signed [FW-1:0] a
   );
      logic signed [EW-1:0] x;
      x = EW'(a);
      if (x > VAL_MAX_E) begin
         clamp_value = VAL_MAX;
      end else if (x < VAL_MIN_E) begin
         clamp_value = VAL_MIN;
      end else begin
         clamp_value = x[VALUE_WIDTH-1:0];
      end
   endfunction

   function automatic logic [KW-1:0] limit_factor(input logic [KW-1:0] f);
      limit_factor = (f > gaeas_pkg::ONE_Q16) ? gaeas_pkg::ONE_Q16 : f;
   endfunction

   // configuration
   logic [KW-1:0]                       gamma_ff;
   logic [KW-1:0]                       lambda_ff;
   logic [gaeas_pkg::MODE_WIDTH-1:0]    mode_ff;
   logic [KW-1:0]                       gamma_lim_ff;
   logic [KW-1:0]                       gamma_lambda_ff;
   logic [KW-1:0]                       gamma_lim_in;
   logic [KW-1:0]                       lambda_lim_in;
   logic [2*KW-1:0]                     gl_prod;
   logic [KW-1:0]                       gamma_lambda_in;

   // pipeline valid bits and advance strobes
   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic ld1, ld2, ld3, ld_out;

   // input register
   logic signed [VALUE_WIDTH-1:0] reward_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic                          not_done_ff;
   logic                          final_ff;

   // stage links
   logic signed [VALUE_WIDTH-1:0] s2_delta;
   logic signed [VALUE_WIDTH-1:0] s2_value;
   gaeas_pkg::step_ctl_type       s2_ctl;
   logic signed [VALUE_WIDTH-1:0] s3_acc;
   logic signed [VALUE_WIDTH-1:0] s3_value;
   logic                          s3_sum_mode;
   logic [FW-1:0]                 adv_ff;
   logic [FW-1:0]                 ret_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff  <= gaeas_pkg::GAMMA_RESET;
         lambda_ff <= gaeas_pkg::LAMBDA_RESET;
         mode_ff   <= gaeas_pkg::MODE_TRAJECTORY;
      end else if (csr_wen) begin
         unique case (csr_index)
            gaeas_pkg::CSR_GAMMA:  gamma_ff  <= csr_wdata;
            gaeas_pkg::CSR_LAMBDA: lambda_ff <= csr_wdata;
            gaeas_pkg::CSR_MODE:   mode_ff   <= csr_wdata[gaeas_pkg::MODE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // factors above one act as one; gamma*lambda rounded to Q1.16
   assign gamma_lim_in    = limit_factor(gamma_ff);
   assign lambda_lim_in   = limit_factor(lambda_ff);
   assign gl_prod         = (2*KW)'(gamma_lim_in) * (2*KW)'(lambda_lim_in)
                            + (2*KW)'(1 << (gaeas_pkg::FRAC_BITS - 1));
   assign gamma_lambda_in = gl_prod[gaeas_pkg::FRAC_BITS +: KW];

   always_ff @(posedge clock) begin
      gamma_lim_ff    <= gamma_lim_in;
      gamma_lambda_ff <= gamma_lambda_in;
   end

   // advance a stage when it is empty or its successor moves on
   assign ld_out     = v3_ff & (~out_v_ff | rsp_tready);
   assign ld3        = v2_ff & (~v3_ff | ld_out);
   assign ld2        = v1_ff & (~v2_ff | ld3);
   assign req_tready = ~v1_ff | ld2;
   assign ld1        = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= ld1 | (v1_ff & ~ld2);
         v2_ff    <= ld2 | (v2_ff & ~ld3);
         v3_ff    <= ld3 | (v3_ff & ~ld_out);
         out_v_ff <= ld_out | (out_v_ff & ~rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         reward_ff   <= clamp_value(req_tdata[FW-1:0]);
         value_ff    <= clamp_value(req_tdata[2*FW-1:FW]);
         not_done_ff <= req_tuser[0];
         final_ff    <= req_tuser[1];
      end
   end

   gaeas_delta #(.VALUE_WIDTH(VALUE_WIDTH)) u_delta (
      .clock      (clock),
      .reset      (reset),
      .load       (ld2),
      .reward     (reward_ff),
      .value      (value_ff),
      .not_done   (not_done_ff),
      .final_step (final_ff),
      .mode       (mode_ff),
      .gamma_lim  (gamma_lim_ff),
      .delta_ff   (s2_delta),
      .value_ff   (s2_value),
      .ctl_ff     (s2_ctl)
   );

   gaeas_accum #(.VALUE_WIDTH(VALUE_WIDTH)) u_accum (
      .clock        (clock),
      .reset        (reset),
      .load         (ld3),
      .delta        (s2_delta),
      .value        (s2_value),
      .ctl          (s2_ctl),
      .gamma_lim    (gamma_lim_ff),
      .gamma_lambda (gamma_lambda_ff),
      .acc_ff       (s3_acc),
      .value_ff     (s3_value),
      .sum_mode_ff  (s3_sum_mode)
   );

   gaeas_out #(.VALUE_WIDTH(VALUE_WIDTH)) u_out (
      .clock        (clock),
      .load         (ld_out),
      .acc          (s3_acc),
      .value        (s3_value),
      .sum_mode     (s3_sum_mode),
      .advantage_ff (adv_ff),
      .return_ff    (ret_ff)
   );

   assign rsp_tdata  = {ret_ff, adv_ff};
   assign rsp_tvalid = out_v_ff;

`ifndef SYNTH
   // input back-pressure only when every stage is full and the result is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff && v2_ff && v3_ff && rsp_tvalid && !rsp_tready)
      else $error("input stalled with a free stage");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v3_ff))
      else $error("result raised without an accumulated item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !v1_ff && !v2_ff && !v3_ff)
      else $error("pipeline not empty after reset");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !v3_ff |=> !rsp_tvalid)
      else $error("result repeated after it was taken");
`endif

endmodule
